// File: sv/vfv_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vfv_pkg
// Shared constants, types and helper functions of the voxel face visibility
// block: grid geometry, face directions and voxel memory request layout.
// ----------------------------------------------------------------------------
package vfv_pkg;

    localparam int GRID_WIDTH  = 32;
    localparam int GRID_HEIGHT = 64;
    localparam int TYPE_BITS   = 4;

    localparam int CELL_COUNT = GRID_WIDTH * GRID_HEIGHT * GRID_WIDTH;
    localparam int CELL_BITS  = $clog2(CELL_COUNT);

    // port field widths
    localparam int X_BITS        = 5;
    localparam int Y_BITS        = 6;
    localparam int Z_BITS        = 5;
    localparam int NEW_TYPE_BITS = 4;
    localparam int CELL_OUT_BITS = 4;
    localparam int MASK_BITS     = 16;
    localparam int MASK_IDX_BITS = $clog2(MASK_BITS);
    localparam int COUNT_BITS    = 6;

    // type 0 is air
    localparam logic [MASK_BITS-1:0] OPAQUE_RESET = 16'hFFFE;

    localparam int FACES          = 6;
    localparam int FACE_BITS      = $clog2(FACES);
    localparam int VERTS_PER_FACE = 6;

    // step counter: one read issued per face, plus a final step for the last beat
    localparam int STEP_BITS = $clog2(FACES + 2);

    // face order: -z, +z, -x, +x, +y, -y
    localparam int FACE_DX [FACES] = '{0, 0, -1, 1, 0, 0};
    localparam int FACE_DY [FACES] = '{0, 0, 0, 0, 1, -1};
    localparam int FACE_DZ [FACES] = '{-1, 1, 0, 0, 0, 0};

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef logic [CELL_BITS-1:0] cell_addr_t;
    typedef logic [TYPE_BITS-1:0] vox_type_t;

    typedef struct packed {
        logic       we;
        cell_addr_t addr;
        vox_type_t  wdata;
    } ram_req_t;

    function automatic logic in_grid(int x, int y, int z);
        return (x >= 0) && (x < GRID_WIDTH) && (y >= 0) && (y < GRID_HEIGHT)
            && (z >= 0) && (z < GRID_WIDTH);
    endfunction

    function automatic cell_addr_t cell_index(int x, int y, int z);
        logic [31:0] idx;
        idx = 32'((x * GRID_WIDTH + z) * GRID_HEIGHT + y);
        return idx[CELL_BITS-1:0];
    endfunction

    function automatic logic type_opaque(logic [MASK_BITS-1:0] mask, vox_type_t t);
        logic [31:0] tw;
        tw = 32'(t);
        return (tw < 32'(MASK_BITS)) && mask[tw[MASK_IDX_BITS-1:0]];
    endfunction

endpackage
`default_nettype wire

// File: sv/vfv_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vfv_ram
// Single-port synchronous RAM, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module vfv_ram #(
    parameter int DEPTH     = 1024,
    parameter int DATA_BITS = 8
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [DATA_BITS-1:0]     wdata,
    output logic      [DATA_BITS-1:0]     rdata
);

    logic [DATA_BITS-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule
`default_nettype wire

// File: sv/vfv_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// vfv_ctrl
// Query sequencer: drives the voxel memory port, walks the queried voxel and
// its six neighbors one read per cycle, and builds the result beat.
// ----------------------------------------------------------------------------
module vfv_ctrl (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    input  wire logic                             func,
    input  wire logic [vfv_pkg::X_BITS-1:0]        pos_x,
    input  wire logic [vfv_pkg::Y_BITS-1:0]        pos_y,
    input  wire logic [vfv_pkg::Z_BITS-1:0]        pos_z,
    input  wire logic [vfv_pkg::NEW_TYPE_BITS-1:0] new_type,
    input  wire logic [vfv_pkg::MASK_BITS-1:0]     opaque_mask,
    output logic                                  busy,
    output vfv_pkg::ram_req_t                     ram_req,
    input  wire vfv_pkg::vox_type_t                ram_rdata,
    output logic                                  done,
    output logic [vfv_pkg::CELL_OUT_BITS-1:0]      cell_type,
    output logic [vfv_pkg::FACES-1:0]              face_mask,
    output logic [vfv_pkg::COUNT_BITS-1:0]         vertex_count
);

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_QUERY = 2'b10
    } state_t;

    state_t                            state_reg, state_next;
    logic [vfv_pkg::STEP_BITS-1:0]     step_reg, step_next;
    logic [vfv_pkg::X_BITS-1:0]        x_reg, x_next;
    logic [vfv_pkg::Y_BITS-1:0]        y_reg, y_next;
    logic [vfv_pkg::Z_BITS-1:0]        z_reg, z_next;
    logic                              center_in_reg, center_in_next;
    logic [vfv_pkg::FACES-1:0]         nbr_in_reg, nbr_in_next;
    vfv_pkg::vox_type_t                type_reg, type_next;
    logic                              opq_reg, opq_next;
    logic [vfv_pkg::FACES-1:0]         mask_reg, mask_next;
    logic                              done_reg, done_next;
    logic [vfv_pkg::CELL_OUT_BITS-1:0] cell_type_reg, cell_type_next;
    logic [vfv_pkg::FACES-1:0]         face_mask_reg, face_mask_next;
    logic [vfv_pkg::COUNT_BITS-1:0]    vertex_count_reg, vertex_count_next;

    logic                              accept;
    logic [vfv_pkg::FACE_BITS-1:0]     rd_face;
    logic [vfv_pkg::FACE_BITS-1:0]     vis_face;
    logic                              visible;
    logic [vfv_pkg::FACES-1:0]         final_mask;
    logic [vfv_pkg::FACE_BITS:0]       face_cnt;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);

    // step n issues the read of face n-1; the beat of face n-2 is on rdata
    always_comb
    begin
        rd_face  = '0;
        vis_face = '0;
        if ((step_reg >= vfv_pkg::STEP_BITS'(1)) &&
            (step_reg <= vfv_pkg::STEP_BITS'(vfv_pkg::FACES)))
        begin
            rd_face = vfv_pkg::FACE_BITS'(step_reg - vfv_pkg::STEP_BITS'(1));
        end
        if ((step_reg >= vfv_pkg::STEP_BITS'(2)) &&
            (step_reg <= vfv_pkg::STEP_BITS'(vfv_pkg::FACES + 1)))
        begin
            vis_face = vfv_pkg::FACE_BITS'(step_reg - vfv_pkg::STEP_BITS'(2));
        end
    end

    assign visible = !nbr_in_reg[vis_face] || !vfv_pkg::type_opaque(opaque_mask, ram_rdata);

    always_comb
    begin
        final_mask = mask_reg;
        final_mask[vfv_pkg::FACES-1] = visible;
        face_cnt = '0;
        for (int i = 0; i < vfv_pkg::FACES; i++)
        begin
            face_cnt = face_cnt + (vfv_pkg::FACE_BITS + 1)'(final_mask[i]);
        end
    end

    // memory port: direct from the input ports while idle
    always_comb
    begin
        ram_req.we    = 1'b0;
        ram_req.wdata = vfv_pkg::TYPE_BITS'(new_type);
        ram_req.addr  = vfv_pkg::cell_index(int'(pos_x), int'(pos_y), int'(pos_z));
        if (state_reg == ST_IDLE)
        begin
            ram_req.we = start && (func == vfv_pkg::FUNC_WRITE)
                && vfv_pkg::in_grid(int'(pos_x), int'(pos_y), int'(pos_z));
        end
        else
        begin
            ram_req.addr = vfv_pkg::cell_index(
                int'(x_reg) + vfv_pkg::FACE_DX[rd_face],
                int'(y_reg) + vfv_pkg::FACE_DY[rd_face],
                int'(z_reg) + vfv_pkg::FACE_DZ[rd_face]);
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        step_next         = step_reg;
        x_next            = x_reg;
        y_next            = y_reg;
        z_next            = z_reg;
        center_in_next    = center_in_reg;
        nbr_in_next       = nbr_in_reg;
        type_next         = type_reg;
        opq_next          = opq_reg;
        mask_next         = mask_reg;
        done_next         = 1'b0;
        cell_type_next    = cell_type_reg;
        face_mask_next    = face_mask_reg;
        vertex_count_next = vertex_count_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (func == vfv_pkg::FUNC_QUERY))
                begin
                    state_next     = ST_QUERY;
                    step_next      = vfv_pkg::STEP_BITS'(1);
                    x_next         = pos_x;
                    y_next         = pos_y;
                    z_next         = pos_z;
                    center_in_next = vfv_pkg::in_grid(int'(pos_x), int'(pos_y), int'(pos_z));
                    for (int f = 0; f < vfv_pkg::FACES; f++)
                    begin
                        nbr_in_next[f] = vfv_pkg::in_grid(
                            int'(pos_x) + vfv_pkg::FACE_DX[f],
                            int'(pos_y) + vfv_pkg::FACE_DY[f],
                            int'(pos_z) + vfv_pkg::FACE_DZ[f]);
                    end
                end
            end
            ST_QUERY:
            begin
                step_next = step_reg + vfv_pkg::STEP_BITS'(1);
                if (step_reg == vfv_pkg::STEP_BITS'(1))
                begin
                    // beat of the queried voxel itself
                    type_next = ram_rdata;
                    opq_next  = vfv_pkg::type_opaque(opaque_mask, ram_rdata);
                    mask_next = '0;
                end
                else
                begin
                    mask_next[vis_face] = visible;
                end
                if (step_reg == vfv_pkg::STEP_BITS'(vfv_pkg::FACES + 1))
                begin
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                    if (center_in_reg)
                    begin
                        cell_type_next = vfv_pkg::CELL_OUT_BITS'(type_reg);
                    end
                    else
                    begin
                        cell_type_next = '0;
                    end
                    if (center_in_reg && opq_reg)
                    begin
                        face_mask_next    = final_mask;
                        vertex_count_next = vfv_pkg::COUNT_BITS'(face_cnt)
                            * vfv_pkg::COUNT_BITS'(vfv_pkg::VERTS_PER_FACE);
                    end
                    else
                    begin
                        face_mask_next    = '0;
                        vertex_count_next = '0;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg            <= x_next;
        y_reg            <= y_next;
        z_reg            <= z_next;
        center_in_reg    <= center_in_next;
        nbr_in_reg       <= nbr_in_next;
        type_reg         <= type_next;
        opq_reg          <= opq_next;
        mask_reg         <= mask_next;
        cell_type_reg    <= cell_type_next;
        face_mask_reg    <= face_mask_next;
        vertex_count_reg <= vertex_count_next;
    end

    assign done         = done_reg;
    assign cell_type    = cell_type_reg;
    assign face_mask    = face_mask_reg;
    assign vertex_count = vertex_count_reg;

endmodule
`default_nettype wire

// File: sv/voxel_face_visibility.sv
`default_nettype none
// ----------------------------------------------------------------------------
// voxel_face_visibility
// Voxel grid of block types with per-voxel face culling query.
// ----------------------------------------------------------------------------
// A write is taken without raising busy, so writes can be issued back to
// back. A query holds busy high once it is taken, with one read of the
// single-port voxel memory per cycle (the voxel, then its six neighbors),
// and no new request is taken while busy is high. The result appears for
// one cycle with done high in the first cycle that busy is low again; the
// receiver cannot stall it, so it must capture every done beat. The voxel
// memory is not cleared at reset: every voxel a query touches must have been
// written.
// ----------------------------------------------------------------------------
module voxel_face_visibility (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic                             func,
    input  wire logic [vfv_pkg::X_BITS-1:0]        pos_x,
    input  wire logic [vfv_pkg::Y_BITS-1:0]        pos_y,
    input  wire logic [vfv_pkg::Z_BITS-1:0]        pos_z,
    input  wire logic [vfv_pkg::NEW_TYPE_BITS-1:0] new_type,
    output logic                                  done,
    output logic [vfv_pkg::CELL_OUT_BITS-1:0]      cell_type,
    output logic [vfv_pkg::FACES-1:0]              face_mask,
    output logic [vfv_pkg::COUNT_BITS-1:0]         vertex_count,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [vfv_pkg::MASK_BITS-1:0]     cfg_data
);

    logic [vfv_pkg::MASK_BITS-1:0] opaque_mask_reg, opaque_mask_next;
    vfv_pkg::ram_req_t             ram_req;
    vfv_pkg::vox_type_t            ram_rdata;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        opaque_mask_next = opaque_mask_reg;
        if (cfg_valid && cfg_ready)
        begin
            opaque_mask_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            opaque_mask_reg <= vfv_pkg::OPAQUE_RESET;
        end
        else
        begin
            opaque_mask_reg <= opaque_mask_next;
        end
    end

    vfv_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .func         (func),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .new_type     (new_type),
        .opaque_mask  (opaque_mask_reg),
        .busy         (busy),
        .ram_req      (ram_req),
        .ram_rdata    (ram_rdata),
        .done         (done),
        .cell_type    (cell_type),
        .face_mask    (face_mask),
        .vertex_count (vertex_count)
    );

    vfv_ram #(
        .DEPTH     (vfv_pkg::CELL_COUNT),
        .DATA_BITS (vfv_pkg::TYPE_BITS)
    ) u_voxel_ram (
        .clk   (clk),
        .we    (ram_req.we),
        .addr  (ram_req.addr),
        .wdata (ram_req.wdata),
        .rdata (ram_rdata)
    );

    // result beat only at the end of a query walk
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(busy) && !busy))
        else $error("done without a preceding query");

    // a query start keeps the block busy
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && func == vfv_pkg::FUNC_QUERY) |=> busy)
        else $error("query taken but block not busy");

    // a write gives no result and does not hold the block
    a_write_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && func == vfv_pkg::FUNC_WRITE) |=> (!busy && !done))
        else $error("write stalled the block or gave a result");

    // memory is never written during a query walk
    a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !ram_req.we)
        else $error("voxel write during query");

    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (int'(vertex_count) == $countones(face_mask) * vfv_pkg::VERTS_PER_FACE))
        else $error("vertex count does not match face mask");

endmodule
`default_nettype wire
